// ===== rtl/core/nat_five_tuple_translator_defines.svh =====
// Assertion macros used by the checker of the translator.
`ifndef NAT_FIVE_TUPLE_TRANSLATOR_DEFINES_SVH
`define NAT_FIVE_TUPLE_TRANSLATOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define NFT_ASSERT_NOW(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("nft assertion failed");

// Next-cycle implication, disabled during reset.
`define NFT_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("nft assertion failed");

// Next-cycle implication that also holds across reset.
`define NFT_ASSERT_NEXT_ALWAYS(lbl, ck, ante, cons) \
  lbl: assert property (@(posedge ck) (ante) |=> (cons)) \
    else $error("nft assertion failed");

`endif

// ===== rtl/core/nft_pkg.sv =====
// Types and constants of the five-tuple NAT translator.
package nft_pkg;

  localparam int TABLE_ENTRIES_DEFAULT = 64;

  typedef struct packed {
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [7:0]  protocol;
  } pkt_t;

  typedef struct packed {
    logic [31:0] new_src_addr;
    logic [31:0] new_dst_addr;
    logic [15:0] new_sport;
    logic [15:0] new_dport;
    logic [7:0]  new_protocol;
    logic [2:0]  verdict;
  } res_t;

  // One stored flow: the inside tuple as it left.
  typedef struct packed {
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [7:0]  protocol;
  } entry_t;

  localparam logic [1:0] CFG_INSIDE_ADDR  = 2'd0;
  localparam logic [1:0] CFG_INSIDE_MASK  = 2'd1;
  localparam logic [1:0] CFG_OUTSIDE_ADDR = 2'd2;

  localparam logic [2:0] VERDICT_LOCAL      = 3'd0;
  localparam logic [2:0] VERDICT_OUT_KNOWN  = 3'd1;
  localparam logic [2:0] VERDICT_OUT_STORED = 3'd2;
  localparam logic [2:0] VERDICT_OUT_FULL   = 3'd3;
  localparam logic [2:0] VERDICT_IN_HIT     = 3'd4;
  localparam logic [2:0] VERDICT_IN_MISS    = 3'd5;
  localparam logic [2:0] VERDICT_IGNORED    = 3'd6;

endpackage

// ===== rtl/core/nat_five_tuple_translator.sv =====
// Top level of the source NAT translator with its flow table memory.
//
// One packet tuple is taken per beat and one result beat is returned for it.
// Local and ignored packets go from accept through the classify and done states
// to their result; outbound and inbound packets walk the flow table from the
// newest entry down, one memory read per cycle, until a match is found or all
// fill_count valid entries are read (TABLE_ENTRIES of them with a full table).
// That walk through the single-port read of the table memory sets the rate.
// Entries are appended in order and never removed; the fill count marks which
// entries are valid, so no clearing pass is needed after reset. A finished
// result sits in an output register, so the next packet is accepted while it
// waits. The configuration port is always ready and is meant to be written
// only while the block is idle.
module nat_five_tuple_translator #(
  parameter int TABLE_ENTRIES = nft_pkg::TABLE_ENTRIES_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          pkt_valid,
  output logic          pkt_ready,
  input  nft_pkg::pkt_t pkt,
  output logic          res_valid,
  input  logic          res_ready,
  output nft_pkg::res_t res,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_index,
  input  logic [31:0]   cfg_data
);

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_ENTRIES);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CLASS,
    S_SEARCH,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    K_LOCAL,
    K_OUT,
    K_IN,
    K_IGNORE
  } kind_t;

  state_t         state;
  kind_t          kind;
  nft_pkg::pkt_t  pkt_q;
  logic [CW-1:0]  fill_count;
  logic [IW-1:0]  issue_idx;
  logic [CW-1:0]  issue_left;
  logic           chk;
  logic           hit;
  logic [31:0]    hit_addr;
  logic [31:0]    inside_addr;
  logic [31:0]    inside_mask;
  logic [31:0]    outside_addr;

  nft_pkg::entry_t table_mem [TABLE_ENTRIES];
  nft_pkg::entry_t rd_entry;
  nft_pkg::entry_t key;

  logic          s_in;
  logic          d_in;
  kind_t         kind_next;
  logic          rd_en;
  logic          wr_en;
  logic [IW-1:0] wr_idx;
  logic          match;
  logic          res_free;
  logic          res_load;
  logic [CW-1:0] fill_last;
  nft_pkg::res_t res_next;

  assign cfg_ready = 1'b1;
  assign pkt_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      inside_addr  <= '0;
      inside_mask  <= '0;
      outside_addr <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        nft_pkg::CFG_INSIDE_ADDR:  inside_addr  <= cfg_data;
        nft_pkg::CFG_INSIDE_MASK:  inside_mask  <= cfg_data;
        nft_pkg::CFG_OUTSIDE_ADDR: outside_addr <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s_in = (pkt_q.src_addr & inside_mask) == (inside_addr & inside_mask);
  assign d_in = (pkt_q.dst_addr & inside_mask) == (inside_addr & inside_mask);

  always_comb begin
    if (s_in && d_in) begin
      kind_next = K_LOCAL;
    end else if (s_in) begin
      kind_next = K_OUT;
    end else if (pkt_q.dst_addr == outside_addr) begin
      kind_next = K_IN;
    end else begin
      kind_next = K_IGNORE;
    end
  end

  assign key = '{src_addr: pkt_q.src_addr, dst_addr: pkt_q.dst_addr,
                 sport: pkt_q.sport, dport: pkt_q.dport,
                 protocol: pkt_q.protocol};

  // Inbound packets match the stored flow with source and destination mirrored.
  always_comb begin
    if (kind == K_OUT) begin
      match = (rd_entry == key);
    end else begin
      match = (rd_entry.dst_addr == pkt_q.src_addr) &&
              (rd_entry.dport == pkt_q.sport) &&
              (rd_entry.sport == pkt_q.dport) &&
              (rd_entry.protocol == pkt_q.protocol);
    end
  end

  always_comb begin
    res_next = '{new_src_addr: pkt_q.src_addr, new_dst_addr: pkt_q.dst_addr,
                 new_sport: pkt_q.sport, new_dport: pkt_q.dport,
                 new_protocol: pkt_q.protocol, verdict: nft_pkg::VERDICT_IGNORED};
    case (kind)
      K_LOCAL: res_next.verdict = nft_pkg::VERDICT_LOCAL;
      K_OUT: begin
        res_next.new_src_addr = outside_addr;
        if (hit) begin
          res_next.verdict = nft_pkg::VERDICT_OUT_KNOWN;
        end else if (fill_count != FULL_COUNT) begin
          res_next.verdict = nft_pkg::VERDICT_OUT_STORED;
        end else begin
          res_next.verdict = nft_pkg::VERDICT_OUT_FULL;
        end
      end
      K_IN: begin
        if (hit) begin
          res_next.new_dst_addr = hit_addr;
          res_next.verdict      = nft_pkg::VERDICT_IN_HIT;
        end else begin
          res_next.verdict = nft_pkg::VERDICT_IN_MISS;
        end
      end
      default: res_next.verdict = nft_pkg::VERDICT_IGNORED;
    endcase
  end

  assign res_free  = !res_valid || res_ready;
  assign res_load  = (state == S_DONE) && res_free;
  assign rd_en     = (state == S_SEARCH) && (issue_left != '0);
  assign wr_en     = res_load && (kind == K_OUT) && !hit && (fill_count != FULL_COUNT);
  assign wr_idx    = fill_count[IW-1:0];
  assign fill_last = fill_count - CW'(1);

  // The insert happens as an item leaves the done state, and the next search starts
  // only after the idle and classify states, so reads never race a pending write.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      table_mem[wr_idx] <= key;
    end
    if (rd_en) begin
      rd_entry <= table_mem[issue_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      res_valid  <= 1'b0;
      fill_count <= '0;
      chk        <= 1'b0;
      hit        <= 1'b0;
      issue_left <= '0;
    end else begin
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (pkt_valid) begin
            pkt_q <= pkt;
            state <= S_CLASS;
          end
        end
        S_CLASS: begin
          kind       <= kind_next;
          hit        <= 1'b0;
          chk        <= 1'b0;
          issue_idx  <= fill_last[IW-1:0];
          issue_left <= fill_count;
          if ((kind_next == K_OUT || kind_next == K_IN) && fill_count != '0) begin
            state <= S_SEARCH;
          end else begin
            state <= S_DONE;
          end
        end
        S_SEARCH: begin
          chk <= rd_en;
          if (rd_en) begin
            issue_idx  <= issue_idx - IW'(1);
            issue_left <= issue_left - CW'(1);
          end
          if (chk && match) begin
            hit      <= 1'b1;
            hit_addr <= rd_entry.src_addr;
            state    <= S_DONE;
          end else if (issue_left == '0) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_free) begin
            res <= res_next;
            if (wr_en) begin
              fill_count <= fill_count + CW'(1);
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/nft_checker.sv =====
// Port-level checker for the translator, bound to the top level.
`include "nat_five_tuple_translator_defines.svh"

module nft_checker (
  input logic          clk,
  input logic          rst,
  input logic          pkt_valid,
  input logic          pkt_ready,
  input logic          res_valid,
  input logic          res_ready,
  input nft_pkg::res_t res
);

  // A stalled result beat keeps its payload.
  `NFT_ASSERT_NEXT(a_res_hold, clk, rst, res_valid && !res_ready, res_valid && $stable(res))

  // Only defined verdict codes leave the block.
  `NFT_ASSERT_NOW(a_verdict_code, clk, rst, res_valid, res.verdict <= nft_pkg::VERDICT_IGNORED)

  // The block works on one packet at a time, so it is busy right after a beat.
  `NFT_ASSERT_NEXT(a_busy_after_accept, clk, rst, pkt_valid && pkt_ready, !pkt_ready)

  // Reset leaves no result pending.
  `NFT_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, rst, !res_valid)

endmodule

bind nat_five_tuple_translator nft_checker u_nft_checker (.*);
